// ===== src/xiks_pkg.sv =====
// ----------------------------------------------------------------------------
// xiks_pkg
// Shared constants, types and helpers of the xor invariant key search block.
// ----------------------------------------------------------------------------
`default_nettype none

package xiks_pkg;

    localparam int KEY_MAX      = 32;
    localparam int BYTE_W       = 8;
    localparam int WORD_W       = 64;
    localparam int KEY_WORDS    = 4;
    localparam int WORD_BYTES   = WORD_W / BYTE_W;
    localparam int KEY_BYTES    = KEY_WORDS * WORD_BYTES;
    localparam int KEY_IDX_W    = $clog2(KEY_BYTES);

    localparam int MODE_W       = 2;
    localparam int LEN_W        = 6;
    localparam int CMP_W        = LEN_W + 1;
    localparam int CNT_W        = $clog2(KEY_MAX + 1);
    localparam int WIN_IDX_W    = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = WORD_W;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_0_7    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_8_15   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_16_23  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_24_31  = 3'd5;

    // scan modes
    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EXACT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_XOR   = 2'd2;

    typedef logic [BYTE_W-1:0]                 t_byte;
    typedef logic [KEY_BYTES-1:0][BYTE_W-1:0]  t_key;

    // key byte by index, bytes past the key registers read as zero
    function automatic t_byte key_byte(input t_key key, input logic [LEN_W-1:0] idx);
        t_byte res;
        res = '0;
        if (CMP_W'(idx) < CMP_W'(KEY_BYTES)) begin
            res = key[idx[KEY_IDX_W-1:0]];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/xiks_if.sv =====
// ----------------------------------------------------------------------------
// xiks_in_if / xiks_out_if
// Valid/ready channels for message bytes and for per-message results.
// ----------------------------------------------------------------------------
`default_nettype none

interface xiks_in_if;
    logic                      valid;
    logic                      ready;
    logic [xiks_pkg::BYTE_W-1:0] data_byte;
    logic                      last_of_message;

    modport source (output valid, output data_byte, output last_of_message, input ready);
    modport sink   (input valid, input data_byte, input last_of_message, output ready);
endinterface

interface xiks_out_if;
    logic valid;
    logic ready;
    logic key_found;

    modport source (output valid, output key_found, input ready);
    modport sink   (input valid, input key_found, output ready);
endinterface

`default_nettype wire

// ===== src/xor_invariant_key_search.sv =====
// ----------------------------------------------------------------------------
// xor_invariant_key_search
// Scans message bytes for a key, exact or under any single-byte xor, and
// reports per message whether the key was seen.
// ----------------------------------------------------------------------------
//  channel   dir  request fields                      handshake
//  i_in      in   data_byte[7:0], last_of_message     valid/ready
//  o_out     out  key_found                           valid/ready
//  i_cfg_*   in   idx[2:0], data[63:0]                we only
//
//  one byte is taken per cycle while the input does not stall; a result passes
//  from the window stage register to the output register, which presents it
//  the window compare over a row of KEY_MAX cells is combinational
//  i_rst_n is synchronous and clears control state and all config registers
//  input stalls only while reset is held or when a finished result would meet
//  a full, stalled output register
// ----------------------------------------------------------------------------
`default_nettype none

module xor_invariant_key_search (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    xiks_in_if.sink                               i_in,
    xiks_out_if.source                            o_out,
    input  wire                                   i_cfg_we,
    input  wire  [xiks_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire  [xiks_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    // configuration
    logic [xiks_pkg::MODE_W-1:0] r_scan_mode;
    logic [xiks_pkg::LEN_W-1:0]  r_key_length;
    xiks_pkg::t_key              r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_mode  <= xiks_pkg::MODE_OFF;
            r_key_length <= '0;
            r_key        <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                xiks_pkg::CFG_SCAN_MODE:  r_scan_mode  <= i_cfg_data[xiks_pkg::MODE_W-1:0];
                xiks_pkg::CFG_KEY_LENGTH: r_key_length <= i_cfg_data[xiks_pkg::LEN_W-1:0];
                xiks_pkg::CFG_KEY_0_7: begin
                    r_key[0*xiks_pkg::WORD_BYTES +: xiks_pkg::WORD_BYTES] <= i_cfg_data;
                end
                xiks_pkg::CFG_KEY_8_15: begin
                    r_key[1*xiks_pkg::WORD_BYTES +: xiks_pkg::WORD_BYTES] <= i_cfg_data;
                end
                xiks_pkg::CFG_KEY_16_23: begin
                    r_key[2*xiks_pkg::WORD_BYTES +: xiks_pkg::WORD_BYTES] <= i_cfg_data;
                end
                xiks_pkg::CFG_KEY_24_31: begin
                    r_key[3*xiks_pkg::WORD_BYTES +: xiks_pkg::WORD_BYTES] <= i_cfg_data;
                end
                default: ;
            endcase
        end
    end

    // window stage control
    logic                         r_s1_valid;
    logic                         r_s1_last;
    logic [xiks_pkg::CNT_W-1:0]   r_s1_count;
    logic [xiks_pkg::CNT_W-1:0]   w_base_count;
    logic [xiks_pkg::CNT_W-1:0]   n_s1_count;
    logic                         r_hit;
    logic                         r_out_valid;
    logic                         r_key_found;
    logic                         w_accept;
    logic                         w_s1_block;
    logic                         w_s1_go;
    logic                         w_win_hit;
    logic                         w_hit_now;

    assign w_s1_block = r_s1_valid && r_s1_last && r_out_valid && !o_out.ready;
    assign w_s1_go    = r_s1_valid && !w_s1_block;
    // no request is taken while reset is held
    assign i_in.ready = i_rst_n && (!r_s1_valid || w_s1_go);
    assign w_accept   = i_in.valid && i_in.ready;

    // message byte count, restarts after a last byte, saturates at the window size
    assign w_base_count = r_s1_last ? '0 : r_s1_count;
    assign n_s1_count   = (w_base_count == xiks_pkg::CNT_W'(xiks_pkg::KEY_MAX))
                          ? w_base_count : w_base_count + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
            r_s1_count <= '0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
            r_s1_last  <= i_in.last_of_message;
            r_s1_count <= n_s1_count;
        end else if (w_s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    // row of window cells, cell 0 holds the newest byte
    xiks_pkg::t_byte              w_cell_byte [xiks_pkg::KEY_MAX];
    xiks_pkg::t_byte              w_cell_diff [xiks_pkg::KEY_MAX];
    logic [xiks_pkg::KEY_MAX-1:0] w_cell_match;
    xiks_pkg::t_byte              w_pad;
    logic [xiks_pkg::WIN_IDX_W-1:0] w_pad_idx;

    genvar k;
    generate
        for (k = 0; k < xiks_pkg::KEY_MAX; k++) begin : g_cell
            xiks_pkg::t_byte              w_in_byte;
            logic                         w_in_use;
            logic [xiks_pkg::LEN_W-1:0]   w_key_idx;

            if (k == 0) begin : g_head
                assign w_in_byte = i_in.data_byte;
            end else begin : g_link
                assign w_in_byte = w_cell_byte[k-1];
            end

            // cell k lines up with key byte (key_length - 1 - k)
            assign w_in_use  = xiks_pkg::CMP_W'(r_key_length) > xiks_pkg::CMP_W'(k);
            assign w_key_idx = r_key_length - xiks_pkg::LEN_W'(k + 1);

            xiks_cell u_cell (
                .i_clk      (i_clk),
                .i_shift    (w_accept),
                .i_byte     (w_in_byte),
                .i_key_byte (xiks_pkg::key_byte(r_key, w_key_idx)),
                .i_pad      (w_pad),
                .i_in_use   (w_in_use),
                .o_byte     (w_cell_byte[k]),
                .o_diff     (w_cell_diff[k]),
                .o_match    (w_cell_match[k])
            );
        end
    endgenerate

    // xor pad comes from the oldest window byte against key byte 0
    assign w_pad_idx = xiks_pkg::WIN_IDX_W'(r_key_length - 1'b1);
    assign w_pad     = (r_scan_mode == xiks_pkg::MODE_XOR) ? w_cell_diff[w_pad_idx] : '0;

    assign w_win_hit = ((r_scan_mode == xiks_pkg::MODE_EXACT) ||
                        (r_scan_mode == xiks_pkg::MODE_XOR))
                    && (r_key_length != '0)
                    && (xiks_pkg::CMP_W'(r_key_length) <= xiks_pkg::CMP_W'(xiks_pkg::KEY_MAX))
                    && (xiks_pkg::CMP_W'(r_s1_count) >= xiks_pkg::CMP_W'(r_key_length))
                    && (&w_cell_match);

    assign w_hit_now = r_hit || w_win_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (w_s1_go) begin
            r_hit <= r_s1_last ? 1'b0 : w_hit_now;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go && r_s1_last) begin
            r_key_found <= w_hit_now;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.key_found = r_key_found;

endmodule

`default_nettype wire

// ===== src/xiks_cell.sv =====
// ----------------------------------------------------------------------------
// xiks_cell
// One window slot: holds a message byte, hands it on to the next slot on
// every shift and compares it against its aligned key byte.
// ----------------------------------------------------------------------------
`default_nettype none

module xiks_cell (
    input  wire                    i_clk,
    input  wire                    i_shift,
    input  wire xiks_pkg::t_byte   i_byte,
    input  wire xiks_pkg::t_byte   i_key_byte,
    input  wire xiks_pkg::t_byte   i_pad,
    input  wire                    i_in_use,
    output xiks_pkg::t_byte        o_byte,
    output xiks_pkg::t_byte        o_diff,
    output logic                   o_match
);

    xiks_pkg::t_byte r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte  = r_byte;
    assign o_diff  = r_byte ^ i_key_byte;
    // slots outside the key length do not take part
    assign o_match = !i_in_use || (o_diff == i_pad);

endmodule

`default_nettype wire
